// ----- hw/rtl/nnis_pkg.sv -----
// Shared constants, types and helper functions for the nearest-neighbor scaler.
// Used by nnis_axis and the scaler core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package nnis_pkg;

   // Depth of the source pixel store; a power of two, so address wrap is a bit-select.
   localparam int SOURCE_DEPTH  = 65536;
   localparam int MAX_DIMENSION = 1024;

   localparam int ADDR_W   = $clog2(SOURCE_DEPTH);
   localparam int DIM_W    = 11;                    // width of each size register
   localparam int COORD_W  = 10;                    // destination coordinate width
   localparam int INDEX_W  = 16;                    // load index width
   localparam int COLOR_W  = 8;
   localparam int PIXEL_W  = 32;
   localparam int CSR_IDX_W = 2;

   // Product of a coordinate and a size, and the source address sum.
   localparam int PROD_W = COORD_W + DIM_W;
   localparam int SUM_W  = 2 * DIM_W + 1;

   // Divider: the quotient is below the source size, so it has DIM_W bits.
   localparam int QUOT_W     = DIM_W;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = (QUOT_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_W      = DIM_W + QUOT_W;

   // Registers from the input register to the clamped source coordinate.
   localparam int AXIS_LAT = DIV_STAGES + 2;

   // Input operation codes.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 2'd3;

   localparam logic [DIM_W-1:0] SRC_WIDTH_RESET  = 11'd320;
   localparam logic [DIM_W-1:0] SRC_HEIGHT_RESET = 11'd200;
   localparam logic [DIM_W-1:0] DST_WIDTH_RESET  = 11'd320;
   localparam logic [DIM_W-1:0] DST_HEIGHT_RESET = 11'd200;

   // Control bits that travel with each beat: at most one of them is set.
   typedef struct packed {
      logic load;
      logic render;
   } ctrl_type;

   // Payload that travels alongside the coordinate mapping.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [INDEX_W-1:0] index;
      logic [PIXEL_W-1:0] argb;
   } item_type;

   // A size register above the maximum dimension acts as the maximum.
   function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (32'(v) > MAX_DIMENSION) begin
         r = DIM_W'(MAX_DIMENSION);
      end
      return r;
   endfunction

   // One restoring division step. The word holds the partial remainder above
   // the dividend bits still to be consumed; quotient bits enter at the bottom.
   function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] w,
                                                 input logic [DIM_W-1:0] d);
      logic [DIM_W:0]    trial;
      logic [DIM_W-1:0]  rem;
      logic [QUOT_W-1:0] nq;
      logic              qbit;
      trial = {w[DIV_W-1:QUOT_W], w[QUOT_W-1]};
      qbit  = (trial >= {1'b0, d});
      if (qbit) begin
         rem = DIM_W'(trial - {1'b0, d});
      end else begin
         rem = trial[DIM_W-1:0];
      end
      nq = {w[QUOT_W-2:0], qbit};
      return {rem, nq};
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nnis_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module nnis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/nnis_axis.sv -----
// One axis of the coordinate mapping: product, pipelined restoring divider and clamp.
// Depends on nnis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nnis_axis
   import nnis_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               adv,
   input  wire logic [COORD_W-1:0] pos,
   input  wire logic [DIM_W-1:0]   src_dim,
   input  wire logic [DIM_W-1:0]   dst_dim,
   output logic      [DIM_W-1:0]   src_pos
);

   logic [PROD_W-1:0] prod_ff;
   logic [DIV_W-1:0]  div_ff [DIV_STAGES];
   logic [DIV_W-1:0]  div_in [DIV_STAGES];
   logic [DIM_W-1:0]  src_pos_ff;
   logic [DIM_W-1:0]  src_pos_in;
   logic [QUOT_W-1:0] quot;

   // Since pos < dst_dim, the top bits of the product are already below the
   // divisor and can seed the remainder directly.
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [DIV_W-1:0] w_start;

      if (k == 0) begin : g_first
         assign w_start = {DIM_W'(prod_ff >> QUOT_W), prod_ff[QUOT_W-1:0]};
      end else begin : g_next
         assign w_start = div_ff[k-1];
      end

      always_comb begin
         logic [DIV_W-1:0] w;
         w = w_start;
         for (int j = 0; j < DIV_STEPS; j++) begin
            if (k * DIV_STEPS + j < QUOT_W) begin
               w = div_step(w, dst_dim);
            end
         end
         div_in[k] = w;
      end
   end

   assign quot = div_ff[DIV_STAGES-1][QUOT_W-1:0];

   always_comb begin
      if (quot >= src_dim) begin
         src_pos_in = src_dim - DIM_W'(1);
      end else begin
         src_pos_in = quot;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= PROD_W'(pos) * PROD_W'(src_dim);
         for (int k = 0; k < DIV_STAGES; k++) begin
            div_ff[k] <= div_in[k];
         end
         src_pos_ff <= src_pos_in;
      end
   end

   assign src_pos = src_pos_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_neighbor_image_scaler_core.sv -----
// Top level of the nearest-neighbor image scaler: registers, beat pipeline, pixel store.
// Depends on nnis_pkg, nnis_axis and nnis_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// -----
// The req channel carries load beats (op = load), which store one RGBA pixel
// at load_index in the source pixel store, and render beats (op = render),
// which name one destination pixel. For each render beat whose coordinate
// lies inside the destination frame, with all four sizes nonzero, the rsp
// channel returns the nearest source pixel packed as ARGB together with the
// destination coordinate. Loads and rejected renders return nothing.
// A beat is taken every cycle the pipeline advances, so the sustained rate is
// one beat per clock while no result is held at the output. A render result
// passes one input register, one multiply stage, six divider stages (two
// quotient bits each but the last), one clamp stage, one address stage and
// the registered read of the pixel store, whose read register is the output.
// Loads write the store at the same stage renders read it, so beats keep
// their order. The whole pipeline advances together; it holds only when a
// result sits in the output and rsp_stall is high, and then req_stall is
// raised. Reset clears all valid bits and restores the default sizes; the
// pixel store is not cleared, and reading a never-written pixel is undefined.
// The csr port should be written only while the pipeline is empty.

module nearest_neighbor_image_scaler_core
   import nnis_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_op,
   input  wire logic [INDEX_W-1:0]   req_load_index,
   input  wire logic [COLOR_W-1:0]   req_red,
   input  wire logic [COLOR_W-1:0]   req_green,
   input  wire logic [COLOR_W-1:0]   req_blue,
   input  wire logic [COLOR_W-1:0]   req_alpha,
   input  wire logic [COORD_W-1:0]   req_dst_x,
   input  wire logic [COORD_W-1:0]   req_dst_y,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [PIXEL_W-1:0]   rsp_pixel_argb,
   output logic      [COORD_W-1:0]   rsp_out_x,
   output logic      [COORD_W-1:0]   rsp_out_y
);

   // Configuration registers.
   logic [DIM_W-1:0] src_width_ff;
   logic [DIM_W-1:0] src_height_ff;
   logic [DIM_W-1:0] dst_width_ff;
   logic [DIM_W-1:0] dst_height_ff;

   // Sizes after limiting to the maximum dimension.
   logic [DIM_W-1:0] sw;
   logic [DIM_W-1:0] sh;
   logic [DIM_W-1:0] dw;
   logic [DIM_W-1:0] dh;

   // The whole pipeline moves on adv.
   logic adv;

   // Input register.
   logic     s0_valid_ff;
   logic     s0_op_ff;
   item_type s0_item_ff;

   // Delay line alongside the axis units.
   ctrl_type p_ctrl_ff [AXIS_LAT];
   item_type p_item_ff [AXIS_LAT];
   ctrl_type p_ctrl_in;

   // Source coordinates from the axis units.
   logic [DIM_W-1:0] src_col;
   logic [DIM_W-1:0] src_row;

   // Address stage.
   ctrl_type            a_ctrl_ff;
   logic [ADDR_W-1:0]   a_addr_ff;
   logic [ADDR_W-1:0]   a_addr_in;
   logic [PIXEL_W-1:0]  a_argb_ff;
   logic [COORD_W-1:0]  a_x_ff;
   logic [COORD_W-1:0]  a_y_ff;
   logic [SUM_W-1:0]    addr_sum;
   logic [31:0]         index_wide;

   // Read stage; the store's read register holds the pixel.
   logic               m_valid_ff;
   logic [COORD_W-1:0] m_x_ff;
   logic [COORD_W-1:0] m_y_ff;

   logic ram_wr_en;
   logic ram_rd_en;

   //------------------------------------------------------------------
   // Configuration
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_WIDTH_RESET;
         src_height_ff <= SRC_HEIGHT_RESET;
         dst_width_ff  <= DST_WIDTH_RESET;
         dst_height_ff <= DST_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata;
            CSR_DST_HEIGHT: dst_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign sw = limit_dim(src_width_ff);
   assign sh = limit_dim(src_height_ff);
   assign dw = limit_dim(dst_width_ff);
   assign dh = limit_dim(dst_height_ff);

   //------------------------------------------------------------------
   // Flow control: only a result held at the output can stop the pipe.
   //------------------------------------------------------------------
   assign adv       = !(m_valid_ff && rsp_stall);
   assign req_stall = !adv;

   //------------------------------------------------------------------
   // Input register
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_op_ff         <= req_op;
         s0_item_ff.x     <= req_dst_x;
         s0_item_ff.y     <= req_dst_y;
         s0_item_ff.index <= req_load_index;
         s0_item_ff.argb  <= {req_alpha, req_red, req_green, req_blue};
      end
   end

   //------------------------------------------------------------------
   // Classification: a render only survives if every size is nonzero and
   // the coordinate is inside the destination frame.
   //------------------------------------------------------------------
   always_comb begin
      p_ctrl_in.load   = s0_valid_ff && (s0_op_ff == OP_LOAD);
      p_ctrl_in.render = s0_valid_ff && (s0_op_ff == OP_RENDER)
                         && (sw != '0) && (sh != '0) && (dw != '0) && (dh != '0)
                         && (DIM_W'(s0_item_ff.x) < dw)
                         && (DIM_W'(s0_item_ff.y) < dh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXIS_LAT; i++) begin
            p_ctrl_ff[i] <= '0;
         end
      end else if (adv) begin
         p_ctrl_ff[0] <= p_ctrl_in;
         for (int i = 1; i < AXIS_LAT; i++) begin
            p_ctrl_ff[i] <= p_ctrl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_item_ff[0] <= s0_item_ff;
         for (int i = 1; i < AXIS_LAT; i++) begin
            p_item_ff[i] <= p_item_ff[i-1];
         end
      end
   end

   //------------------------------------------------------------------
   // Coordinate mapping, one unit per axis.
   //------------------------------------------------------------------
   nnis_axis u_axis_x (
      .clock   (clock),
      .adv     (adv),
      .pos     (s0_item_ff.x),
      .src_dim (sw),
      .dst_dim (dw),
      .src_pos (src_col)
   );

   nnis_axis u_axis_y (
      .clock   (clock),
      .adv     (adv),
      .pos     (s0_item_ff.y),
      .src_dim (sh),
      .dst_dim (dh),
      .src_pos (src_row)
   );

   //------------------------------------------------------------------
   // Address stage: row * width + column for renders, the index for loads,
   // both wrapped to the store depth.
   //------------------------------------------------------------------
   assign addr_sum   = SUM_W'(src_row) * SUM_W'(sw) + SUM_W'(src_col);
   assign index_wide = 32'(p_item_ff[AXIS_LAT-1].index);

   always_comb begin
      if (p_ctrl_ff[AXIS_LAT-1].load) begin
         a_addr_in = index_wide[ADDR_W-1:0];
      end else begin
         a_addr_in = addr_sum[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
      end else if (adv) begin
         a_ctrl_ff <= p_ctrl_ff[AXIS_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_addr_ff <= a_addr_in;
         a_argb_ff <= p_item_ff[AXIS_LAT-1].argb;
         a_x_ff    <= p_item_ff[AXIS_LAT-1].x;
         a_y_ff    <= p_item_ff[AXIS_LAT-1].y;
      end
   end

   //------------------------------------------------------------------
   // Pixel store. Loads and renders use it at the same stage, so a render
   // always sees exactly the loads that were accepted before it.
   //------------------------------------------------------------------
   assign ram_wr_en = adv && a_ctrl_ff.load;
   assign ram_rd_en = adv && a_ctrl_ff.render;

   nnis_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (SOURCE_DEPTH)
   ) u_pixels (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (a_addr_ff),
      .wr_data (a_argb_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (a_addr_ff),
      .rd_data (rsp_pixel_argb)
   );

   //------------------------------------------------------------------
   // Output stage
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= a_ctrl_ff.render;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_x_ff <= a_x_ff;
         m_y_ff <= a_y_ff;
      end
   end

   assign rsp_valid = m_valid_ff;
   assign rsp_out_x = m_x_ff;
   assign rsp_out_y = m_y_ff;

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   a_store_one_access : assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("pixel store written and read in the same cycle");

   a_kind_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(a_ctrl_ff.load && a_ctrl_ff.render))
      else $error("address stage beat marked both load and render");

   a_render_reaches_output : assert property (@(posedge clock) disable iff (reset)
      adv && a_ctrl_ff.render |=> m_valid_ff)
      else $error("render beat lost between address stage and output");

   a_stall_holds_pipe : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(a_ctrl_ff) && $stable(p_ctrl_ff[0]) && $stable(a_addr_ff))
      else $error("pipeline moved while output was stalled");

endmodule

`default_nettype wire
